### src/arc_pkg.sv
package arc_pkg;

	// Field widths of one table entry.
	localparam int unsigned IP_W  = 32;
	localparam int unsigned MAC_W = 48;

	// Operation codes carried on the opcode field.
	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_INSERT = 1'b1;

	// Search token that walks down the row of cells, one cell per cycle.
	typedef struct packed {
		logic             act;
		logic             hit;
		logic [IP_W-1:0]  key;
		logic [MAC_W-1:0] mac;
	} srch_t;

endpackage

### src/arc_cell.sv
module arc_cell #(
	parameter bit BROADCAST = 1'b0
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [arc_pkg::IP_W-1:0]    wr_ip,
	input  logic [arc_pkg::MAC_W-1:0]   wr_mac,
	input  arc_pkg::srch_t              tok_in,
	output arc_pkg::srch_t              tok_out
);
	import arc_pkg::*;

	logic             valid_q;
	logic [IP_W-1:0]  ip_q;
	logic [MAC_W-1:0] mac_q;
	logic             tok_act_q;
	srch_t            tok_nxt;
	srch_t            tok_data_q;

	// Entry storage; the broadcast cell comes out of reset holding the all-ones mapping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= BROADCAST;
			ip_q    <= BROADCAST ? {IP_W{1'b1}} : '0;
			mac_q   <= BROADCAST ? {MAC_W{1'b1}} : '0;
		end else if (wr_en) begin
			valid_q <= 1'b1;
			ip_q    <= wr_ip;
			mac_q   <= wr_mac;
		end
	end

	// A token that has not yet hit takes this entry when it matches, so the lowest cell wins.
	always_comb begin
		tok_nxt = tok_in;
		if (tok_in.act && !tok_in.hit && valid_q && (ip_q == tok_in.key)) begin
			tok_nxt.hit = 1'b1;
			tok_nxt.mac = mac_q;
		end
	end

	// Hand the token to the next cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_act_q <= 1'b0;
		end else begin
			tok_act_q <= tok_nxt.act;
		end
	end

	always_ff @(posedge clk) begin
		tok_data_q <= tok_nxt;
	end

	always_comb begin
		tok_out     = tok_data_q;
		tok_out.act = tok_act_q;
	end

endmodule

### src/address_resolution_cache_core.sv
// A lookup's token passes one cell of the search row per cycle, and its result is then
// registered at the output; the input stall drops as the token leaves the row, unless
// the result has to go to the skid slot. An insert writes its entry and the next item may follow directly.
// One insert per cycle is taken while the input is not stalled; only one lookup is in flight at a time.
// After reset entry 0 holds the broadcast mapping, all other entries are invalid and the
// replacement pointer stands at 1.
module address_resolution_cache_core #(
	parameter int unsigned ENTRIES = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        opcode,
	input  logic [arc_pkg::IP_W-1:0]    ip_address,
	input  logic [arc_pkg::MAC_W-1:0]   mac_address,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        hit,
	output logic [arc_pkg::MAC_W-1:0]   mac_found
);
	import arc_pkg::*;

	localparam int unsigned SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(ENTRIES - 1);
	localparam logic [SLOT_W-1:0] RESET_SLOT = SLOT_W'(1 % ENTRIES);

	srch_t              tok [ENTRIES+1];
	logic               in_fire;
	logic               lookup_fire;
	logic               insert_fire;
	logic               out_fire;
	srch_t              tail;
	logic               searching_q;
	logic [SLOT_W-1:0]  next_q;
	logic               out_valid_q;
	logic               out_hit_q;
	logic [MAC_W-1:0]   out_mac_q;
	logic               skid_valid_q;
	logic               skid_hit_q;
	logic [MAC_W-1:0]   skid_mac_q;

	// Input transfer: one search in flight at a time, and a free skid slot for its result.
	assign in_stall    = searching_q | skid_valid_q;
	assign in_fire     = in_valid & ~in_stall;
	assign lookup_fire = in_fire & (opcode == OP_LOOKUP);
	assign insert_fire = in_fire & (opcode == OP_INSERT);
	assign out_fire    = out_valid_q & ~out_stall;

	// A new search token enters the head of the row.
	always_comb begin
		tok[0].act = lookup_fire;
		tok[0].hit = 1'b0;
		tok[0].key = ip_address;
		tok[0].mac = '0;
	end

	// Row of entry cells; the write strobe is decoded from the replacement pointer.
	for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
		arc_cell #(
			.BROADCAST (k == 0)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.wr_en   (insert_fire && (next_q == SLOT_W'(k))),
			.wr_ip   (ip_address),
			.wr_mac  (mac_address),
			.tok_in  (tok[k]),
			.tok_out (tok[k+1])
		);
	end

	assign tail = tok[ENTRIES];

	// Search-in-progress flag and round-robin replacement pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			searching_q <= 1'b0;
			next_q      <= RESET_SLOT;
		end else begin
			if (lookup_fire) begin
				searching_q <= 1'b1;
			end else if (tail.act) begin
				searching_q <= 1'b0;
			end
			if (insert_fire) begin
				next_q <= (next_q == LAST_SLOT) ? '0 : next_q + SLOT_W'(1);
			end
		end
	end

	// Output register with one skid slot behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (tail.act) begin
				if (!out_valid_q || (out_fire && !skid_valid_q)) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end else if (out_fire) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tail.act) begin
			if (!out_valid_q || (out_fire && !skid_valid_q)) begin
				out_hit_q <= tail.hit;
				out_mac_q <= tail.mac;
			end else begin
				skid_hit_q <= tail.hit;
				skid_mac_q <= tail.mac;
			end
		end else if (out_fire && skid_valid_q) begin
			out_hit_q <= skid_hit_q;
			out_mac_q <= skid_mac_q;
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = out_hit_q;
	assign mac_found = out_mac_q;

	// A finished search must always find room in the output register or the skid slot.
	assert property (@(posedge clk) disable iff (!arst_n) tail.act |-> !skid_valid_q)
		else $error("search result arrived with no free output slot");

	// The skid slot is only used behind a full output register.
	assert property (@(posedge clk) disable iff (!arst_n) skid_valid_q |-> out_valid_q)
		else $error("skid slot full while output register empty");

	// Every accepted lookup marks the row busy until its token leaves the tail.
	assert property (@(posedge clk) disable iff (!arst_n) lookup_fire |=> searching_q)
		else $error("lookup accepted without starting a search");

	// No token reaches the tail unless a search is in progress.
	assert property (@(posedge clk) disable iff (!arst_n) tail.act |-> searching_q)
		else $error("stray search token at end of row");

	// The replacement pointer never leaves the table.
	assert property (@(posedge clk) disable iff (!arst_n) next_q <= LAST_SLOT)
		else $error("replacement pointer out of range");

endmodule
